### sv/qtse_pkg.sv
// Shared types, constants and helper functions for the quadratic triangle shape evaluator.
package qtse_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NODE_COUNT = 6;
    localparam int WIDE_W     = 68;
    localparam int RAD_W      = 128;
    localparam int ROOT_W     = 64;
    localparam int DIVD_W     = 80;
    localparam int QUO_W      = 31;

    localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] Q_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(64'sd2147483648);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;
    localparam logic AXIS_X   = 1'b0;
    localparam logic AXIS_Y   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_INDEX  = 3'd1,
        ST_BAD_AXIS   = 3'd2,
        ST_DEGENERATE = 3'd3,
        ST_SINGULAR   = 3'd4
    } status_t;

    typedef enum logic {
        MODE_DIV  = 1'b0,
        MODE_SQRT = 1'b1
    } unit_mode_t;

    typedef struct packed {
        logic              req_type;
        logic [2:0]        node_slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [2:0]        shape_index;
        logic [1:0]        deriv_axis;
    } req_t;

    typedef struct packed {
        logic signed [31:0] shape_value;
        logic signed [31:0] derivative;
        logic [2:0]         status;
    } rsp_t;

    typedef struct packed {
        logic       start;
        unit_mode_t mode;
    } unit_ctrl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } unit_stat_t;

    // Clamp a wide signed value into signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > SAT_HI)
                r = Q_MAX;
            else if (v < SAT_LO)
                r = Q_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // Parent-coordinate derivative of shape idx along xi (dim 0) or eta (dim 1)
    function automatic logic signed [31:0] parent_deriv(
        input logic [2:0]         idx,
        input logic               dim,
        input logic signed [31:0] l1,
        input logic signed [31:0] l2,
        input logic signed [31:0] l3
    );
        logic signed [35:0] f1;
        logic signed [35:0] f2;
        logic signed [35:0] f3;
        logic signed [35:0] one_w;
        logic signed [35:0] v;
        begin
            f1    = 36'(l1) <<< 2;
            f2    = 36'(l2) <<< 2;
            f3    = 36'(l3) <<< 2;
            one_w = 36'(ONE_Q);
            case (idx)
                3'd0: v = one_w - f1;
                3'd1: v = (dim == AXIS_X) ? f2 - one_w : 36'sd0;
                3'd2: v = (dim == AXIS_Y) ? f3 - one_w : 36'sd0;
                3'd3: v = (dim == AXIS_X) ? f1 - f2 : -f2;
                3'd4: v = (dim == AXIS_X) ? f3 : f2;
                default: v = (dim == AXIS_X) ? -f3 : f1 - f3;
            endcase
            return sat32(WIDE_W'(v));
        end
    endfunction

endpackage

### sv/qtse_iter_unit.sv
// Iterative square root and restoring divider sharing one wide subtractor.
module qtse_iter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qtse_pkg::unit_ctrl_t            ctrl,
    input  logic [qtse_pkg::RAD_W-1:0]      radicand,
    input  logic [qtse_pkg::DIVD_W-1:0]     dividend,
    input  logic [qtse_pkg::ROOT_W-1:0]     divisor,
    output qtse_pkg::unit_stat_t            stat,
    output logic [qtse_pkg::ROOT_W-1:0]     result
);

    logic                busy_reg;
    logic                done_reg;
    qtse_pkg::unit_mode_t mode_reg;
    logic [5:0]          cnt_reg;
    logic [65:0]         rem_reg;
    logic [127:0]        src_reg;
    logic [63:0]         den_reg;
    logic [63:0]         res_reg;
    logic                sat_reg;

    logic [67:0] sub_a;
    logic [67:0] sub_b;
    logic [68:0] diff;
    logic        geq;
    logic        pre_sat;

    // Quotient would reach 2^31: flag at start and skip the iterations
    assign pre_sat = (64'(dividend[79:31]) >= divisor);

    // Pick the trial operands for the current mode
    always_comb
    begin
        if (mode_reg == qtse_pkg::MODE_SQRT)
        begin
            sub_a = {rem_reg, src_reg[127:126]};
            sub_b = {2'b00, res_reg, 2'b01};
        end
        else
        begin
            sub_a = {2'b00, rem_reg[64:0], src_reg[127]};
            sub_b = {4'b0000, den_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        geq  = ~diff[68];
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= qtse_pkg::MODE_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                mode_reg <= ctrl.mode;
                if (ctrl.mode == qtse_pkg::MODE_SQRT)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 6'(qtse_pkg::ROOT_W - 1);
                end
                else if (pre_sat)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 6'(qtse_pkg::QUO_W - 1);
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    // Advance remainder, source bits and result
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            res_reg <= '0;
            den_reg <= divisor;
            sat_reg <= (ctrl.mode == qtse_pkg::MODE_DIV) && pre_sat;
            if (ctrl.mode == qtse_pkg::MODE_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= radicand;
            end
            else
            begin
                rem_reg <= 66'(dividend[79:31]);
                src_reg <= {dividend[30:0], 97'd0};
            end
        end
        else if (busy_reg)
        begin
            res_reg <= {res_reg[62:0], geq};
            rem_reg <= geq ? diff[65:0] : sub_a[65:0];
            if (mode_reg == qtse_pkg::MODE_SQRT)
                src_reg <= {src_reg[125:0], 2'b00};
            else
                src_reg <= {src_reg[126:0], 1'b0};
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign result    = res_reg;

endmodule

### sv/quadratic_triangle_shape_eval.sv
// Top level: node store, sequencer and shared multiplier of the P2 triangle evaluator.
//
// Usage: the req channel carries load and evaluate transfers (valid/stall).
// A load writes the coordinates of one of six nodes and answers at once with zeros.
// An evaluate forms area ratios xi and eta with cross products, a 64-step
// square root and 31-step divisions, then the shape value, a six-node
// Jacobian and the derivative on the chosen axis, all through one 33x33
// multiplier and one root/divide unit.
// A load or a rejected evaluate passes through S_DONE into the rsp register.
// A full evaluate works three area norms (each ending in a square root),
// two ratios, the Jacobian sum and the final divide, in that order.
// The root/divide unit sets the pace.
// One item is worked at a time; req_stall is high from acceptance until
// the result is moved into the rsp register.
// A finished result waits in the rsp register while rsp_stall is high; the
// next request is already taken meanwhile, and the sequencer holds its
// result until the register frees.
// Reset clears the node store to zero and empties the rsp register.
module quadratic_triangle_shape_eval (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  qtse_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output qtse_pkg::rsp_t rsp
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DIFF   = 12'b0000_0000_0010,
        S_CROSS  = 12'b0000_0000_0100,
        S_SQUARE = 12'b0000_0000_1000,
        S_ROOT   = 12'b0000_0001_0000,
        S_RATIO  = 12'b0000_0010_0000,
        S_LAMBDA = 12'b0000_0100_0000,
        S_SHAPE  = 12'b0000_1000_0000,
        S_JAC    = 12'b0001_0000_0000,
        S_DET    = 12'b0010_0000_0000,
        S_FDIV   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg;
    logic [4:0]         step_reg;
    logic [1:0]         tri_reg;
    logic               rsel_reg;
    logic               rsp_valid_reg;
    qtse_pkg::rsp_t     rsp_reg;

    logic signed [31:0] node_x_reg [qtse_pkg::NODE_COUNT];
    logic signed [31:0] node_y_reg [qtse_pkg::NODE_COUNT];
    logic signed [31:0] node_z_reg [qtse_pkg::NODE_COUNT];

    logic signed [31:0] pt_reg [3];
    logic [2:0]         idx_reg;
    logic               axis_reg;
    logic signed [31:0] d1_reg [3];
    logic signed [31:0] d2_reg [3];
    logic signed [64:0] cr_reg [3];
    logic [127:0]       sum_reg;
    logic [63:0]        total_reg;
    logic [63:0]        area1_reg;
    logic [63:0]        area2_reg;
    logic signed [31:0] xi_reg;
    logic signed [31:0] eta_reg;
    logic signed [31:0] l1_reg;
    logic signed [34:0] acc_reg [2][2];
    logic signed [64:0] det_reg;
    logic signed [64:0] num_reg;
    logic               neg_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] sv_reg;
    logic signed [31:0] dv_reg;
    qtse_pkg::status_t  status_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [4:0]         prev_step;
    logic [3:0]         sq_cur;
    logic [3:0]         sq_prev;
    logic signed [64:0] cr_sel;
    logic [63:0]        cr_mag;
    logic signed [31:0] ta [3];
    logic signed [31:0] tb [3];
    logic signed [31:0] tc [3];
    logic signed [31:0] jac [2][2];
    logic signed [31:0] rhs0;
    logic signed [31:0] rhs1;
    logic signed [31:0] pd_jac;
    logic signed [31:0] qprod;
    logic [63:0]        det_mag;
    logic [63:0]        detq_mag;
    logic [63:0]        num_mag;
    logic               accept;
    logic               bad_slot;
    logic               bad_idx;
    logic               bad_axis;
    logic               rsp_free;
    logic               start_sqrt;
    logic               start_div;

    qtse_pkg::unit_ctrl_t        unit_ctrl;
    qtse_pkg::unit_stat_t        unit_stat;
    logic [qtse_pkg::DIVD_W-1:0] unit_dividend;
    logic [qtse_pkg::ROOT_W-1:0] unit_divisor;
    logic [qtse_pkg::ROOT_W-1:0] unit_result;

    // Map a square step onto {cross component, partial product}
    function automatic logic [3:0] sq_decode(input logic [4:0] s);
        logic [3:0] r;
        begin
            case (s)
                5'd0:    r = {2'd0, 2'd0};
                5'd1:    r = {2'd0, 2'd1};
                5'd2:    r = {2'd0, 2'd2};
                5'd3:    r = {2'd1, 2'd0};
                5'd4:    r = {2'd1, 2'd1};
                5'd5:    r = {2'd1, 2'd2};
                5'd6:    r = {2'd2, 2'd0};
                5'd7:    r = {2'd2, 2'd1};
                5'd8:    r = {2'd2, 2'd2};
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign bad_slot  = (req.node_slot >= 3'(qtse_pkg::NODE_COUNT));
    assign bad_idx   = (req.shape_index >= 3'(qtse_pkg::NODE_COUNT));
    assign bad_axis  = (req.deriv_axis > 2'(qtse_pkg::AXIS_Y));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign prev_step = step_reg - 5'd1;
    assign sq_cur    = sq_decode(step_reg);
    assign sq_prev   = sq_decode(prev_step);

    // Triangle corners for the current area norm
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ta[k] = pt_reg[k];
            tb[k] = 32'sd0;
            tc[k] = 32'sd0;
        end
        tb[0] = node_x_reg[0];
        tb[1] = node_y_reg[0];
        tb[2] = node_z_reg[0];
        case (tri_reg)
            2'd0:
            begin
                ta[0] = node_x_reg[0];
                ta[1] = node_y_reg[0];
                ta[2] = node_z_reg[0];
                tb[0] = node_x_reg[1];
                tb[1] = node_y_reg[1];
                tb[2] = node_z_reg[1];
                tc[0] = node_x_reg[2];
                tc[1] = node_y_reg[2];
                tc[2] = node_z_reg[2];
            end
            2'd1:
            begin
                tc[0] = node_x_reg[2];
                tc[1] = node_y_reg[2];
                tc[2] = node_z_reg[2];
            end
            default:
            begin
                tc[0] = node_x_reg[1];
                tc[1] = node_y_reg[1];
                tc[2] = node_z_reg[1];
            end
        endcase
    end

    // Derived values around the shared multiplier
    always_comb
    begin
        cr_sel = cr_reg[sq_cur[3:2]];
        cr_mag = cr_sel[64] ? 64'(-cr_sel) : 64'(cr_sel);
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                jac[r][c] = qtse_pkg::sat32(qtse_pkg::WIDE_W'(acc_reg[r][c]));
            end
        end
        rhs0     = qtse_pkg::parent_deriv(idx_reg, qtse_pkg::AXIS_X, l1_reg, xi_reg, eta_reg);
        rhs1     = qtse_pkg::parent_deriv(idx_reg, qtse_pkg::AXIS_Y, l1_reg, xi_reg, eta_reg);
        pd_jac   = qtse_pkg::parent_deriv(step_reg[4:2], step_reg[1], l1_reg, xi_reg,
                                          eta_reg);
        qprod    = qtse_pkg::sat32(qtse_pkg::WIDE_W'(prod_reg >>> qtse_pkg::FRAC_BITS));
        det_mag  = det_reg[64] ? 64'(-det_reg) : 64'(det_reg);
        detq_mag = det_mag >> qtse_pkg::FRAC_BITS;
        num_mag  = num_reg[64] ? 64'(-num_reg) : 64'(num_reg);
    end

    // Select multiplier operands for the issuing step
    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        unique case (state_reg)
            S_CROSS:
            begin
                case (step_reg[2:0])
                    3'd0:
                    begin
                        mul_a = 33'(d1_reg[1]);
                        mul_b = 33'(d2_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(d1_reg[2]);
                        mul_b = 33'(d2_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = 33'(d1_reg[2]);
                        mul_b = 33'(d2_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = 33'(d1_reg[0]);
                        mul_b = 33'(d2_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = 33'(d1_reg[0]);
                        mul_b = 33'(d2_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = 33'(d1_reg[1]);
                        mul_b = 33'(d2_reg[0]);
                    end
                    default:
                    begin
                        mul_a = 33'sd0;
                        mul_b = 33'sd0;
                    end
                endcase
            end
            S_SQUARE:
            begin
                case (sq_cur[1:0])
                    2'd0:
                    begin
                        mul_a = $signed({1'b0, cr_mag[63:32]});
                        mul_b = $signed({1'b0, cr_mag[63:32]});
                    end
                    2'd1:
                    begin
                        mul_a = $signed({1'b0, cr_mag[63:32]});
                        mul_b = $signed({1'b0, cr_mag[31:0]});
                    end
                    default:
                    begin
                        mul_a = $signed({1'b0, cr_mag[31:0]});
                        mul_b = $signed({1'b0, cr_mag[31:0]});
                    end
                endcase
            end
            S_SHAPE:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        mul_a = 33'(qtse_pkg::sat32((qtse_pkg::WIDE_W'(l1_reg) <<< 1)
                                - qtse_pkg::WIDE_W'(qtse_pkg::ONE_Q)));
                        mul_b = 33'(l1_reg);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(qtse_pkg::sat32((qtse_pkg::WIDE_W'(xi_reg) <<< 1)
                                - qtse_pkg::WIDE_W'(qtse_pkg::ONE_Q)));
                        mul_b = 33'(xi_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 33'(qtse_pkg::sat32((qtse_pkg::WIDE_W'(eta_reg) <<< 1)
                                - qtse_pkg::WIDE_W'(qtse_pkg::ONE_Q)));
                        mul_b = 33'(eta_reg);
                    end
                    3'd3:
                    begin
                        mul_a = 33'(l1_reg);
                        mul_b = 33'(xi_reg);
                    end
                    3'd4:
                    begin
                        mul_a = 33'(xi_reg);
                        mul_b = 33'(eta_reg);
                    end
                    default:
                    begin
                        mul_a = 33'(eta_reg);
                        mul_b = 33'(l1_reg);
                    end
                endcase
            end
            S_JAC:
            begin
                if (step_reg[4:2] < 3'(qtse_pkg::NODE_COUNT))
                begin
                    mul_a = step_reg[0] ? 33'(node_y_reg[step_reg[4:2]])
                                        : 33'(node_x_reg[step_reg[4:2]]);
                    mul_b = 33'(pd_jac);
                end
            end
            S_DET:
            begin
                case (step_reg[2:0])
                    3'd0:
                    begin
                        mul_a = 33'(jac[0][0]);
                        mul_b = 33'(jac[1][1]);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(jac[0][1]);
                        mul_b = 33'(jac[1][0]);
                    end
                    3'd2:
                    begin
                        mul_a = (axis_reg == qtse_pkg::AXIS_X) ? 33'(rhs0) : 33'(jac[0][0]);
                        mul_b = (axis_reg == qtse_pkg::AXIS_X) ? 33'(jac[1][1]) : 33'(rhs1);
                    end
                    3'd3:
                    begin
                        mul_a = (axis_reg == qtse_pkg::AXIS_X) ? 33'(jac[0][1]) : 33'(rhs0);
                        mul_b = (axis_reg == qtse_pkg::AXIS_X) ? 33'(rhs1) : 33'(jac[1][0]);
                    end
                    default:
                    begin
                        mul_a = 33'sd0;
                        mul_b = 33'sd0;
                    end
                endcase
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // Launch the root/divide unit
    always_comb
    begin
        start_sqrt = (state_reg == S_SQUARE) && (step_reg == 5'd10);
        start_div  = ((state_reg == S_ROOT) && unit_stat.done && (tri_reg == 2'd2))
                  || ((state_reg == S_RATIO) && unit_stat.done && !rsel_reg)
                  || ((state_reg == S_DET) && (step_reg == 5'd5) && (detq_mag != 64'd0));
        unit_ctrl.start = start_sqrt || start_div;
        unit_ctrl.mode  = start_sqrt ? qtse_pkg::MODE_SQRT : qtse_pkg::MODE_DIV;
        if (state_reg == S_DET)
        begin
            unit_dividend = {16'd0, num_mag};
            unit_divisor  = detq_mag;
        end
        else if (state_reg == S_ROOT)
        begin
            unit_dividend = {area1_reg, 16'd0};
            unit_divisor  = total_reg;
        end
        else
        begin
            unit_dividend = {area2_reg, 16'd0};
            unit_divisor  = total_reg;
        end
    end

    qtse_iter_unit u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (unit_ctrl),
        .radicand (sum_reg),
        .dividend (unit_dividend),
        .divisor  (unit_divisor),
        .stat     (unit_stat),
        .result   (unit_result)
    );

    // Sequencer, node store and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            tri_reg       <= '0;
            rsel_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < qtse_pkg::NODE_COUNT; i++)
            begin
                node_x_reg[i] <= 32'sd0;
                node_y_reg[i] <= 32'sd0;
                node_z_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            // Drop the result once the receiver takes it, unless a new one replaces it
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg <= '0;
                        tri_reg  <= '0;
                        rsel_reg <= 1'b0;
                        if (req.req_type == qtse_pkg::REQ_LOAD)
                        begin
                            if (!bad_slot)
                            begin
                                node_x_reg[req.node_slot] <= req.coord_x;
                                node_y_reg[req.node_slot] <= req.coord_y;
                                node_z_reg[req.node_slot] <= req.coord_z;
                            end
                            state_reg <= S_DONE;
                        end
                        else if (bad_idx || bad_axis)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF:
                begin
                    step_reg  <= '0;
                    state_reg <= S_CROSS;
                end
                S_CROSS:
                begin
                    if (step_reg == 5'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_SQUARE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_SQUARE:
                begin
                    if (step_reg == 5'd10)
                        state_reg <= S_ROOT;
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_ROOT:
                begin
                    if (unit_stat.done)
                    begin
                        if (tri_reg == 2'd0 && unit_result == 64'd0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (tri_reg == 2'd2)
                        begin
                            state_reg <= S_RATIO;
                        end
                        else
                        begin
                            tri_reg   <= tri_reg + 2'd1;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_RATIO:
                begin
                    if (unit_stat.done)
                    begin
                        if (rsel_reg)
                            state_reg <= S_LAMBDA;
                        else
                            rsel_reg <= 1'b1;
                    end
                end
                S_LAMBDA:
                begin
                    step_reg  <= '0;
                    state_reg <= S_SHAPE;
                end
                S_SHAPE:
                begin
                    if (step_reg == 5'd1)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_JAC;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_JAC:
                begin
                    if (step_reg == 5'd24)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_DET;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_DET:
                begin
                    if (step_reg == 5'd5)
                        state_reg <= (detq_mag == 64'd0) ? S_DONE : S_FDIV;
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_FDIV:
                begin
                    if (unit_stat.done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(mul_a) * 66'(mul_b);

        unique case (state_reg)
            S_IDLE:
            begin
                pt_reg[0] <= req.coord_x;
                pt_reg[1] <= req.coord_y;
                pt_reg[2] <= req.coord_z;
                idx_reg   <= req.shape_index;
                axis_reg  <= req.deriv_axis[0];
                sv_reg    <= 32'sd0;
                dv_reg    <= 32'sd0;
                if (req.req_type == qtse_pkg::REQ_LOAD)
                    status_reg <= bad_slot ? qtse_pkg::ST_BAD_INDEX : qtse_pkg::ST_OK;
                else if (bad_idx)
                    status_reg <= qtse_pkg::ST_BAD_INDEX;
                else if (bad_axis)
                    status_reg <= qtse_pkg::ST_BAD_AXIS;
                else
                    status_reg <= qtse_pkg::ST_OK;
            end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d1_reg[k] <= qtse_pkg::sat32(qtse_pkg::WIDE_W'(tb[k])
                                 - qtse_pkg::WIDE_W'(ta[k]));
                    d2_reg[k] <= qtse_pkg::sat32(qtse_pkg::WIDE_W'(tc[k])
                                 - qtse_pkg::WIDE_W'(ta[k]));
                end
                sum_reg <= '0;
            end
            S_CROSS:
            begin
                // Set a component on even steps, subtract on odd ones
                if (step_reg != 5'd0)
                begin
                    if (prev_step[0])
                        cr_reg[prev_step[2:1]] <= cr_reg[prev_step[2:1]] - 65'(prod_reg);
                    else
                        cr_reg[prev_step[2:1]] <= 65'(prod_reg);
                end
            end
            S_SQUARE:
            begin
                if (step_reg != 5'd0 && step_reg != 5'd10)
                begin
                    case (sq_prev[1:0])
                        2'd0:    sum_reg <= sum_reg + (128'(prod_reg[63:0]) << 64);
                        2'd1:    sum_reg <= sum_reg + (128'(prod_reg[63:0]) << 33);
                        default: sum_reg <= sum_reg + 128'(prod_reg[63:0]);
                    endcase
                end
            end
            S_ROOT:
            begin
                if (unit_stat.done)
                begin
                    case (tri_reg)
                        2'd0:
                        begin
                            total_reg <= unit_result;
                            if (unit_result == 64'd0)
                                status_reg <= qtse_pkg::ST_DEGENERATE;
                        end
                        2'd1:    area1_reg <= unit_result;
                        default: area2_reg <= unit_result;
                    endcase
                end
            end
            S_RATIO:
            begin
                if (unit_stat.done)
                begin
                    if (rsel_reg)
                        eta_reg <= unit_stat.sat ? qtse_pkg::Q_MAX
                                                 : $signed({1'b0, unit_result[30:0]});
                    else
                        xi_reg <= unit_stat.sat ? qtse_pkg::Q_MAX
                                                : $signed({1'b0, unit_result[30:0]});
                end
            end
            S_LAMBDA:
            begin
                l1_reg <= qtse_pkg::sat32(qtse_pkg::WIDE_W'(qtse_pkg::ONE_Q)
                          - qtse_pkg::WIDE_W'(xi_reg) - qtse_pkg::WIDE_W'(eta_reg));
            end
            S_SHAPE:
            begin
                if (step_reg == 5'd1)
                begin
                    if (idx_reg >= 3'd3)
                        sv_reg <= qtse_pkg::sat32(qtse_pkg::WIDE_W'(qprod) <<< 2);
                    else
                        sv_reg <= qprod;
                    for (int r = 0; r < 2; r++)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            acc_reg[r][c] <= 35'sd0;
                        end
                    end
                end
            end
            S_JAC:
            begin
                if (step_reg != 5'd0)
                    acc_reg[prev_step[1]][prev_step[0]] <=
                        acc_reg[prev_step[1]][prev_step[0]] + 35'(qprod);
            end
            S_DET:
            begin
                case (step_reg[2:0])
                    3'd1:    det_reg <= 65'(prod_reg);
                    3'd2:    det_reg <= det_reg - 65'(prod_reg);
                    3'd3:    num_reg <= 65'(prod_reg);
                    3'd4:    num_reg <= num_reg - 65'(prod_reg);
                    3'd5:
                    begin
                        neg_reg <= num_reg[64] ^ det_reg[64];
                        if (detq_mag == 64'd0)
                            status_reg <= qtse_pkg::ST_SINGULAR;
                    end
                    default: ;
                endcase
            end
            S_FDIV:
            begin
                if (unit_stat.done)
                begin
                    if (unit_stat.sat)
                        dv_reg <= neg_reg ? qtse_pkg::Q_MIN : qtse_pkg::Q_MAX;
                    else if (neg_reg)
                        dv_reg <= -$signed({1'b0, unit_result[30:0]});
                    else
                        dv_reg <= $signed({1'b0, unit_result[30:0]});
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_reg.shape_value <= sv_reg;
                    rsp_reg.derivative  <= dv_reg;
                    rsp_reg.status      <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
